[hdl/grid_fixed_radius_pair_finder_defines.svh]
// Assertion macros shared by the pair finder RTL.
// Depends on nothing; the including module must have clk and rst_n.
`ifndef GRID_FIXED_RADIUS_PAIR_FINDER_DEFINES_SVH
`define GRID_FIXED_RADIUS_PAIR_FINDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GFR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/gfr_pkg.sv]
// Package for the grid pair finder: word types, request and status codes,
// and the sequencer state type. Depends on nothing.
package gfr_pkg;

    localparam int COORD_W = 16;
    localparam int TYPE_W  = 8;
    localparam int ID_W    = 10;
    localparam int THR_W   = 16;
    localparam int STAT_W  = 3;
    localparam int REQ_W   = 2;

    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BUILD = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FETCH = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

    localparam logic [STAT_W-1:0] ST_ACCEPTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_PAIR      = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_MORE   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [TYPE_W-1:0]  feature_type;
        logic [ID_W-1:0]    point_id;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ID_W-1:0]    first_id;
        logic [TYPE_W-1:0]  first_type;
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] first_y;
        logic [ID_W-1:0]    second_id;
        logic [TYPE_W-1:0]  second_type;
        logic [COORD_W-1:0] second_x;
        logic [COORD_W-1:0] second_y;
    } rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [TYPE_W-1:0]  ftype;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } pt_t;

    localparam int PT_W = $bits(pt_t);

    typedef enum logic [5:0] {
        S_IDLE, S_LOAD, S_CLEAR, S_FETCH,
        B_START, B_BRD, B_BUPD, B_DXK, B_DXW, B_DYK, B_DYW, B_DMUL, B_DCHK,
        B_CLR, B_CRD, B_CXK, B_CXW, B_CYK, B_CYW, B_CMUL, B_CIDX, B_CINC,
        B_PRD, B_PWR, B_LRD, B_LCS, B_LWR, B_SRD, B_SWR,
        F_TOP, F_END, F_NPOS, F_POS, F_RANGE, F_LO, F_HI, F_CAND,
        F_IA, F_IB, F_PA, F_PB, F_SQX, F_SQY, F_SQR, F_CMP
    } state_t;

endpackage

[hdl/gfr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module gfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/gfr_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the grid-sizing and point-binning build steps.
// Depends on nothing.
module gfr_div #(
    parameter int WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] num,
    input  logic [WIDTH-1:0] den,
    output logic [WIDTH-1:0] quot,
    output logic             done
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] q_reg, q_next;
    logic [WIDTH:0]   rem_reg, rem_next;
    logic [WIDTH-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH+1:0] trial;

    always_comb
    begin
        shifted   = {rem_reg[WIDTH-1:0], q_reg[WIDTH-1]};
        trial     = {1'b0, shifted} - {2'b00, den_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next   = num;
            rem_next = '0;
            den_next = den;
            cnt_next = CNT_W'(WIDTH);
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[WIDTH+1])
            begin
                rem_next = trial[WIDTH:0];
                q_next   = {q_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            q_reg    <= q_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

[hdl/grid_fixed_radius_pair_finder.sv]
// Load, clear and a fetch without a ready grid finish in their first work state.
// A build finds the bounding box, sizes the grid, clears the cell counts, bins
// each point with the shared divider, prefix-sums the counts and orders the points.
// A fetch walks the cell positions and tries each candidate in turn.
// One word at a time; busy stays high until done pulses.
// Reset clears the point count, grid and cursor; the threshold resets to 1.
module grid_fixed_radius_pair_finder #(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_CELLS  = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  gfr_pkg::req_t             req,
    output logic                      busy,
    output logic                      done,
    output gfr_pkg::rsp_t             rsp,
    input  logic                      cfg_we,
    input  logic [gfr_pkg::THR_W-1:0] cfg_data
);

    `include "grid_fixed_radius_pair_finder_defines.svh"

    localparam int CW   = gfr_pkg::COORD_W;
    localparam int PAW  = $clog2(MAX_POINTS);
    localparam int PCW  = $clog2(MAX_POINTS + 1);
    localparam int CAW  = $clog2(MAX_CELLS + 1);
    localparam int CW2  = CAW + 1;
    localparam int DIMW = CW + 1;
    localparam int MW   = 2 * DIMW;
    localparam int NW   = ((CAW > DIMW) ? CAW : DIMW) + 2;

    localparam logic [2:0] PH_SAME  = 3'd0;
    localparam logic [2:0] PH_UP    = 3'd1;
    localparam logic [2:0] PH_RDOWN = 3'd2;
    localparam logic [2:0] PH_RIGHT = 3'd3;
    localparam logic [2:0] PH_RUP   = 3'd4;

    gfr_pkg::state_t state_reg, state_next;

    logic [gfr_pkg::THR_W-1:0] thr_reg;
    gfr_pkg::req_t             req_reg;
    logic [PCW-1:0]            count_reg;
    logic                      ready_reg;
    logic [CW-1:0]             min_x_reg, min_y_reg, max_x_reg, max_y_reg;
    logic [DIMW-1:0]           cells_x_reg, cells_y_reg;
    logic [CAW-1:0]            total_reg;
    logic [PCW-1:0]            k_reg;
    logic [CW2-1:0]            c_reg;
    logic [PCW-1:0]            acc_reg;
    logic [CW-1:0]             qx_reg, qy_reg;
    logic [CAW-1:0]            cidx_reg;
    logic [CAW-1:0]            cell_reg;
    logic [DIMW-1:0]           cx_reg, cy_reg;
    logic [PCW-1:0]            pos_reg, koff_reg, end_reg, lo_reg, hi_reg;
    logic [2:0]                phase_reg;
    logic [CAW-1:0]            nidx_reg;
    logic [PAW-1:0]            ia_reg;
    gfr_pkg::pt_t              pa_reg, pb_reg;
    logic [CW-1:0]             dx_reg, dy_reg;
    logic [MW-1:0]             mul_reg;
    logic [MW:0]               sq_reg;
    logic                      done_reg;
    gfr_pkg::rsp_t             rsp_reg;

    // Memories
    logic                      ps_we, ps_re;
    logic [PAW-1:0]            ps_waddr, ps_raddr;
    gfr_pkg::pt_t              ps_wdata, ps_rd;
    logic [gfr_pkg::PT_W-1:0]  ps_rdata;
    logic                      bo_we, bo_re;
    logic [PAW-1:0]            bo_waddr, bo_raddr, bo_wdata, bo_rdata;
    logic                      cr_we, cr_re;
    logic [PAW-1:0]            cr_waddr, cr_raddr;
    logic [CAW-1:0]            cr_wdata, cr_rdata;
    logic                      cs_we, cs_re;
    logic [CAW-1:0]            cs_waddr, cs_raddr;
    logic [PCW-1:0]            cs_wdata, cs_rdata;

    // Shared divider and multiplier
    logic                      div_start, div_done;
    logic [CW-1:0]             div_num, div_den, div_q;
    logic [DIMW-1:0]           mul_a, mul_b;

    // Sequencer outputs
    logic                      fin;
    logic                      fin_pair;
    logic [gfr_pkg::STAT_W-1:0] fin_status;

    // Helpers
    logic                      accept;
    logic [CW-1:0]             edge_len;
    logic [PCW-1:0]            kp1;
    logic                      k_last;
    logic [CAW-1:0]            c_calc;
    logic [CAW-1:0]            cell_p1;
    logic [PCW:0]              cand;
    logic                      cand_ok;
    logic                      nx_ok, up_ok, dn_ok, nb_ok;
    logic [NW-1:0]             nb_idx;

    assign accept   = start && (state_reg == gfr_pkg::S_IDLE);
    assign edge_len = (thr_reg == '0) ? CW'(1) : thr_reg;
    assign kp1      = k_reg + PCW'(1);
    assign k_last   = (kp1 == count_reg);
    assign c_calc   = CAW'(mul_reg + MW'(qy_reg));
    assign cell_p1  = cell_reg + CAW'(1);
    assign cand     = (PCW+1)'(lo_reg) + (PCW+1)'(koff_reg);
    assign cand_ok  = cand < {1'b0, hi_reg};
    assign ps_rd    = gfr_pkg::pt_t'(ps_rdata);

    always_comb
    begin
        nx_ok = ((DIMW+1)'(cx_reg) + (DIMW+1)'(1)) < (DIMW+1)'(cells_x_reg);
        up_ok = ((DIMW+1)'(cy_reg) + (DIMW+1)'(1)) < (DIMW+1)'(cells_y_reg);
        dn_ok = (cy_reg != '0);
        case (phase_reg)
            PH_UP:
            begin
                nb_ok  = up_ok;
                nb_idx = NW'(cell_reg) + NW'(1);
            end
            PH_RDOWN:
            begin
                nb_ok  = nx_ok && dn_ok;
                nb_idx = NW'(cell_reg) + NW'(cells_y_reg) - NW'(1);
            end
            PH_RIGHT:
            begin
                nb_ok  = nx_ok;
                nb_idx = NW'(cell_reg) + NW'(cells_y_reg);
            end
            PH_RUP:
            begin
                nb_ok  = nx_ok && up_ok;
                nb_idx = NW'(cell_reg) + NW'(cells_y_reg) + NW'(1);
            end
            default:
            begin
                nb_ok  = 1'b0;
                nb_idx = '0;
            end
        endcase
    end

    // Output logic: memory ports, shared unit operands, completion.
    always_comb
    begin
        ps_we = 1'b0; ps_waddr = '0; ps_re = 1'b0; ps_raddr = '0;
        ps_wdata = '0;
        bo_we = 1'b0; bo_waddr = '0; bo_wdata = '0; bo_re = 1'b0; bo_raddr = '0;
        cr_we = 1'b0; cr_waddr = '0; cr_wdata = '0; cr_re = 1'b0; cr_raddr = '0;
        cs_we = 1'b0; cs_waddr = '0; cs_wdata = '0; cs_re = 1'b0; cs_raddr = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = edge_len;
        mul_a      = '0;
        mul_b      = '0;
        fin        = 1'b0;
        fin_pair   = 1'b0;
        fin_status = gfr_pkg::ST_ACCEPTED;
        case (state_reg)
            gfr_pkg::S_LOAD:
            begin
                fin = 1'b1;
                if (count_reg == PCW'(MAX_POINTS))
                begin
                    fin_status = gfr_pkg::ST_FULL;
                end
                else
                begin
                    ps_we    = 1'b1;
                    ps_waddr = count_reg[PAW-1:0];
                    ps_wdata = '{id: req_reg.point_id, ftype: req_reg.feature_type,
                                 x: req_reg.pos_x, y: req_reg.pos_y};
                end
            end
            gfr_pkg::S_CLEAR:
            begin
                fin = 1'b1;
            end
            gfr_pkg::S_FETCH:
            begin
                if (!ready_reg)
                begin
                    fin        = 1'b1;
                    fin_status = gfr_pkg::ST_NO_MORE;
                end
            end
            gfr_pkg::B_START:
            begin
                fin = (count_reg == '0);
            end
            gfr_pkg::B_BRD, gfr_pkg::B_CRD:
            begin
                ps_re    = 1'b1;
                ps_raddr = k_reg[PAW-1:0];
            end
            gfr_pkg::B_DXK:
            begin
                div_start = 1'b1;
                div_num   = max_x_reg - min_x_reg;
            end
            gfr_pkg::B_DYK:
            begin
                div_start = 1'b1;
                div_num   = max_y_reg - min_y_reg;
            end
            gfr_pkg::B_DMUL:
            begin
                mul_a = cells_x_reg;
                mul_b = cells_y_reg;
            end
            gfr_pkg::B_DCHK:
            begin
                if (mul_reg > MW'(MAX_CELLS))
                begin
                    fin        = 1'b1;
                    fin_status = gfr_pkg::ST_TOO_LARGE;
                end
            end
            gfr_pkg::B_CLR:
            begin
                cs_we    = 1'b1;
                cs_waddr = c_reg[CAW-1:0];
            end
            gfr_pkg::B_CXK:
            begin
                div_start = 1'b1;
                div_num   = ps_rd.x - min_x_reg;
            end
            gfr_pkg::B_CYK:
            begin
                div_start = 1'b1;
                div_num   = ps_rd.y - min_y_reg;
            end
            gfr_pkg::B_CMUL:
            begin
                mul_a = DIMW'(qx_reg);
                mul_b = cells_y_reg;
            end
            gfr_pkg::B_CIDX:
            begin
                cr_we    = 1'b1;
                cr_waddr = k_reg[PAW-1:0];
                cr_wdata = c_calc;
                cs_re    = 1'b1;
                cs_raddr = c_calc + CAW'(1);
            end
            gfr_pkg::B_CINC:
            begin
                cs_we    = 1'b1;
                cs_waddr = cidx_reg + CAW'(1);
                cs_wdata = cs_rdata + PCW'(1);
            end
            gfr_pkg::B_PRD:
            begin
                cs_re    = 1'b1;
                cs_raddr = c_reg[CAW-1:0];
            end
            gfr_pkg::B_PWR:
            begin
                cs_we    = 1'b1;
                cs_waddr = c_reg[CAW-1:0];
                cs_wdata = cs_rdata + acc_reg;
            end
            gfr_pkg::B_LRD:
            begin
                cr_re    = 1'b1;
                cr_raddr = k_reg[PAW-1:0];
            end
            gfr_pkg::B_LCS:
            begin
                cs_re    = 1'b1;
                cs_raddr = cr_rdata;
            end
            gfr_pkg::B_LWR:
            begin
                bo_we    = 1'b1;
                bo_waddr = cs_rdata[PAW-1:0];
                bo_wdata = k_reg[PAW-1:0];
                cs_we    = 1'b1;
                cs_waddr = cr_rdata;
                cs_wdata = cs_rdata + PCW'(1);
            end
            gfr_pkg::B_SRD:
            begin
                if (c_reg == '0)
                begin
                    cs_we    = 1'b1;
                    cs_waddr = '0;
                    fin      = 1'b1;
                end
                else
                begin
                    cs_re    = 1'b1;
                    cs_raddr = CAW'(c_reg - CW2'(1));
                end
            end
            gfr_pkg::B_SWR:
            begin
                cs_we    = 1'b1;
                cs_waddr = c_reg[CAW-1:0];
                cs_wdata = cs_rdata;
            end
            gfr_pkg::F_TOP:
            begin
                if (cell_reg >= total_reg)
                begin
                    fin        = 1'b1;
                    fin_status = gfr_pkg::ST_NO_MORE;
                end
                else
                begin
                    cs_re    = 1'b1;
                    cs_raddr = cell_p1;
                end
            end
            gfr_pkg::F_NPOS:
            begin
                cs_re    = 1'b1;
                cs_raddr = cell_reg;
            end
            gfr_pkg::F_RANGE:
            begin
                if (phase_reg != PH_SAME && nb_ok)
                begin
                    cs_re    = 1'b1;
                    cs_raddr = nb_idx[CAW-1:0];
                end
            end
            gfr_pkg::F_LO:
            begin
                cs_re    = 1'b1;
                cs_raddr = nidx_reg + CAW'(1);
            end
            gfr_pkg::F_CAND:
            begin
                if (cand_ok)
                begin
                    bo_re    = 1'b1;
                    bo_raddr = pos_reg[PAW-1:0];
                end
            end
            gfr_pkg::F_IA:
            begin
                bo_re    = 1'b1;
                bo_raddr = cand[PAW-1:0];
            end
            gfr_pkg::F_IB:
            begin
                ps_re    = 1'b1;
                ps_raddr = ia_reg;
            end
            gfr_pkg::F_PA:
            begin
                ps_re    = 1'b1;
                ps_raddr = bo_rdata;
            end
            gfr_pkg::F_SQX:
            begin
                mul_a = DIMW'(dx_reg);
                mul_b = DIMW'(dx_reg);
            end
            gfr_pkg::F_SQY:
            begin
                mul_a = DIMW'(dy_reg);
                mul_b = DIMW'(dy_reg);
            end
            gfr_pkg::F_SQR:
            begin
                mul_a = DIMW'(thr_reg);
                mul_b = DIMW'(thr_reg);
            end
            gfr_pkg::F_CMP:
            begin
                if (pa_reg.ftype != pb_reg.ftype && sq_reg <= (MW+1)'(mul_reg))
                begin
                    fin        = 1'b1;
                    fin_pair   = 1'b1;
                    fin_status = gfr_pkg::ST_PAIR;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        if (fin)
        begin
            state_next = gfr_pkg::S_IDLE;
        end
        else
        begin
            case (state_reg)
                gfr_pkg::S_IDLE:
                begin
                    if (accept)
                    begin
                        case (req.req_type)
                            gfr_pkg::REQ_LOAD:  state_next = gfr_pkg::S_LOAD;
                            gfr_pkg::REQ_BUILD: state_next = gfr_pkg::B_START;
                            gfr_pkg::REQ_FETCH: state_next = gfr_pkg::S_FETCH;
                            default:            state_next = gfr_pkg::S_CLEAR;
                        endcase
                    end
                end
                gfr_pkg::S_FETCH: state_next = gfr_pkg::F_TOP;
                gfr_pkg::B_START: state_next = gfr_pkg::B_BRD;
                gfr_pkg::B_BRD:   state_next = gfr_pkg::B_BUPD;
                gfr_pkg::B_BUPD:  state_next = k_last ? gfr_pkg::B_DXK : gfr_pkg::B_BRD;
                gfr_pkg::B_DXK:   state_next = gfr_pkg::B_DXW;
                gfr_pkg::B_DXW:   state_next = div_done ? gfr_pkg::B_DYK : gfr_pkg::B_DXW;
                gfr_pkg::B_DYK:   state_next = gfr_pkg::B_DYW;
                gfr_pkg::B_DYW:   state_next = div_done ? gfr_pkg::B_DMUL : gfr_pkg::B_DYW;
                gfr_pkg::B_DMUL:  state_next = gfr_pkg::B_DCHK;
                gfr_pkg::B_DCHK:  state_next = gfr_pkg::B_CLR;
                gfr_pkg::B_CLR:
                begin
                    if (c_reg[CAW-1:0] == total_reg)
                    begin
                        state_next = gfr_pkg::B_CRD;
                    end
                end
                gfr_pkg::B_CRD:   state_next = gfr_pkg::B_CXK;
                gfr_pkg::B_CXK:   state_next = gfr_pkg::B_CXW;
                gfr_pkg::B_CXW:   state_next = div_done ? gfr_pkg::B_CYK : gfr_pkg::B_CXW;
                gfr_pkg::B_CYK:   state_next = gfr_pkg::B_CYW;
                gfr_pkg::B_CYW:   state_next = div_done ? gfr_pkg::B_CMUL : gfr_pkg::B_CYW;
                gfr_pkg::B_CMUL:  state_next = gfr_pkg::B_CIDX;
                gfr_pkg::B_CIDX:  state_next = gfr_pkg::B_CINC;
                gfr_pkg::B_CINC:  state_next = k_last ? gfr_pkg::B_PRD : gfr_pkg::B_CRD;
                gfr_pkg::B_PRD:   state_next = gfr_pkg::B_PWR;
                gfr_pkg::B_PWR:
                begin
                    state_next = (c_reg[CAW-1:0] == total_reg) ? gfr_pkg::B_LRD
                                                               : gfr_pkg::B_PRD;
                end
                gfr_pkg::B_LRD:   state_next = gfr_pkg::B_LCS;
                gfr_pkg::B_LCS:   state_next = gfr_pkg::B_LWR;
                gfr_pkg::B_LWR:   state_next = k_last ? gfr_pkg::B_SRD : gfr_pkg::B_LRD;
                gfr_pkg::B_SRD:   state_next = gfr_pkg::B_SWR;
                gfr_pkg::B_SWR:   state_next = gfr_pkg::B_SRD;
                gfr_pkg::F_TOP:   state_next = gfr_pkg::F_END;
                gfr_pkg::F_END:
                begin
                    state_next = (pos_reg >= cs_rdata) ? gfr_pkg::F_NPOS : gfr_pkg::F_RANGE;
                end
                gfr_pkg::F_NPOS:  state_next = gfr_pkg::F_POS;
                gfr_pkg::F_POS:   state_next = gfr_pkg::F_TOP;
                gfr_pkg::F_RANGE:
                begin
                    state_next = (phase_reg != PH_SAME && nb_ok) ? gfr_pkg::F_LO
                                                                 : gfr_pkg::F_CAND;
                end
                gfr_pkg::F_LO:    state_next = gfr_pkg::F_HI;
                gfr_pkg::F_HI:    state_next = gfr_pkg::F_CAND;
                gfr_pkg::F_CAND:  state_next = cand_ok ? gfr_pkg::F_IA : gfr_pkg::F_TOP;
                gfr_pkg::F_IA:    state_next = gfr_pkg::F_IB;
                gfr_pkg::F_IB:    state_next = gfr_pkg::F_PA;
                gfr_pkg::F_PA:    state_next = gfr_pkg::F_PB;
                gfr_pkg::F_PB:    state_next = gfr_pkg::F_SQX;
                gfr_pkg::F_SQX:   state_next = gfr_pkg::F_SQY;
                gfr_pkg::F_SQY:   state_next = gfr_pkg::F_SQR;
                gfr_pkg::F_SQR:   state_next = gfr_pkg::F_CMP;
                gfr_pkg::F_CMP:   state_next = gfr_pkg::F_CAND;
                default:          state_next = gfr_pkg::S_IDLE;
            endcase
        end
    end

    // Registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= gfr_pkg::S_IDLE;
            thr_reg     <= gfr_pkg::THR_W'(1);
            req_reg     <= '0;
            count_reg   <= '0;
            ready_reg   <= 1'b0;
            min_x_reg   <= '0;
            min_y_reg   <= '0;
            max_x_reg   <= '0;
            max_y_reg   <= '0;
            cells_x_reg <= '0;
            cells_y_reg <= '0;
            total_reg   <= '0;
            k_reg       <= '0;
            c_reg       <= '0;
            acc_reg     <= '0;
            qx_reg      <= '0;
            qy_reg      <= '0;
            cidx_reg    <= '0;
            cell_reg    <= '0;
            cx_reg      <= '0;
            cy_reg      <= '0;
            pos_reg     <= '0;
            koff_reg    <= '0;
            end_reg     <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            phase_reg   <= PH_SAME;
            nidx_reg    <= '0;
            ia_reg      <= '0;
            pa_reg      <= '0;
            pb_reg      <= '0;
            dx_reg      <= '0;
            dy_reg      <= '0;
            mul_reg     <= '0;
            sq_reg      <= '0;
            done_reg    <= 1'b0;
            rsp_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mul_reg   <= MW'(mul_a) * MW'(mul_b);
            done_reg  <= fin;
            if (fin)
            begin
                rsp_reg <= '0;
                rsp_reg.status <= fin_status;
                if (fin_pair)
                begin
                    rsp_reg.first_id    <= pa_reg.id;
                    rsp_reg.first_type  <= pa_reg.ftype;
                    rsp_reg.first_x     <= pa_reg.x;
                    rsp_reg.first_y     <= pa_reg.y;
                    rsp_reg.second_id   <= pb_reg.id;
                    rsp_reg.second_type <= pb_reg.ftype;
                    rsp_reg.second_x    <= pb_reg.x;
                    rsp_reg.second_y    <= pb_reg.y;
                end
            end
            if (cfg_we)
            begin
                thr_reg <= cfg_data;
            end
            if (accept)
            begin
                req_reg <= req;
            end
            case (state_reg)
                gfr_pkg::S_LOAD:
                begin
                    if (count_reg != PCW'(MAX_POINTS))
                    begin
                        count_reg <= count_reg + PCW'(1);
                        ready_reg <= 1'b0;
                    end
                end
                gfr_pkg::S_CLEAR:
                begin
                    count_reg <= '0;
                    ready_reg <= 1'b0;
                    cell_reg  <= '0;
                    cx_reg    <= '0;
                    cy_reg    <= '0;
                    pos_reg   <= '0;
                    phase_reg <= PH_SAME;
                    koff_reg  <= '0;
                end
                gfr_pkg::B_START:
                begin
                    ready_reg <= (count_reg == '0);
                    cell_reg  <= '0;
                    cx_reg    <= '0;
                    cy_reg    <= '0;
                    pos_reg   <= '0;
                    phase_reg <= PH_SAME;
                    koff_reg  <= '0;
                    k_reg     <= '0;
                    if (count_reg == '0)
                    begin
                        min_x_reg   <= '0;
                        min_y_reg   <= '0;
                        max_x_reg   <= '0;
                        max_y_reg   <= '0;
                        cells_x_reg <= '0;
                        cells_y_reg <= '0;
                        total_reg   <= '0;
                    end
                end
                gfr_pkg::B_BUPD:
                begin
                    if (k_reg == '0 || ps_rd.x < min_x_reg)
                    begin
                        min_x_reg <= ps_rd.x;
                    end
                    if (k_reg == '0 || ps_rd.x > max_x_reg)
                    begin
                        max_x_reg <= ps_rd.x;
                    end
                    if (k_reg == '0 || ps_rd.y < min_y_reg)
                    begin
                        min_y_reg <= ps_rd.y;
                    end
                    if (k_reg == '0 || ps_rd.y > max_y_reg)
                    begin
                        max_y_reg <= ps_rd.y;
                    end
                    k_reg <= kp1;
                end
                gfr_pkg::B_DXW:
                begin
                    if (div_done)
                    begin
                        cells_x_reg <= DIMW'(div_q) + DIMW'(1);
                    end
                end
                gfr_pkg::B_DYW:
                begin
                    if (div_done)
                    begin
                        cells_y_reg <= DIMW'(div_q) + DIMW'(1);
                    end
                end
                gfr_pkg::B_DCHK:
                begin
                    total_reg <= mul_reg[CAW-1:0];
                    c_reg     <= '0;
                end
                gfr_pkg::B_CLR:
                begin
                    c_reg <= c_reg + CW2'(1);
                    k_reg <= '0;
                end
                gfr_pkg::B_CXW:
                begin
                    if (div_done)
                    begin
                        qx_reg <= div_q;
                    end
                end
                gfr_pkg::B_CYW:
                begin
                    if (div_done)
                    begin
                        qy_reg <= div_q;
                    end
                end
                gfr_pkg::B_CIDX:
                begin
                    cidx_reg <= c_calc;
                end
                gfr_pkg::B_CINC:
                begin
                    k_reg   <= kp1;
                    c_reg   <= CW2'(1);
                    acc_reg <= '0;
                end
                gfr_pkg::B_PWR:
                begin
                    acc_reg <= cs_rdata + acc_reg;
                    c_reg   <= c_reg + CW2'(1);
                    k_reg   <= '0;
                end
                gfr_pkg::B_LWR:
                begin
                    k_reg <= kp1;
                    c_reg <= CW2'(total_reg);
                end
                gfr_pkg::B_SRD:
                begin
                    if (c_reg == '0)
                    begin
                        ready_reg <= 1'b1;
                    end
                end
                gfr_pkg::B_SWR:
                begin
                    c_reg <= c_reg - CW2'(1);
                end
                gfr_pkg::F_END:
                begin
                    end_reg <= cs_rdata;
                    if (pos_reg >= cs_rdata)
                    begin
                        // Move to the next cell in x-major order.
                        cell_reg  <= cell_p1;
                        phase_reg <= PH_SAME;
                        koff_reg  <= '0;
                        if (cy_reg + DIMW'(1) == cells_y_reg)
                        begin
                            cy_reg <= '0;
                            cx_reg <= cx_reg + DIMW'(1);
                        end
                        else
                        begin
                            cy_reg <= cy_reg + DIMW'(1);
                        end
                    end
                end
                gfr_pkg::F_POS:
                begin
                    pos_reg <= cs_rdata;
                end
                gfr_pkg::F_RANGE:
                begin
                    nidx_reg <= nb_idx[CAW-1:0];
                    if (phase_reg == PH_SAME)
                    begin
                        lo_reg <= pos_reg + PCW'(1);
                        hi_reg <= end_reg;
                    end
                    else if (!nb_ok)
                    begin
                        lo_reg <= '0;
                        hi_reg <= '0;
                    end
                end
                gfr_pkg::F_LO:
                begin
                    lo_reg <= cs_rdata;
                end
                gfr_pkg::F_HI:
                begin
                    hi_reg <= cs_rdata;
                end
                gfr_pkg::F_CAND:
                begin
                    if (!cand_ok)
                    begin
                        koff_reg <= '0;
                        if (phase_reg == PH_RUP)
                        begin
                            phase_reg <= PH_SAME;
                            pos_reg   <= pos_reg + PCW'(1);
                        end
                        else
                        begin
                            phase_reg <= phase_reg + 3'd1;
                        end
                    end
                end
                gfr_pkg::F_IA:
                begin
                    ia_reg <= bo_rdata;
                end
                gfr_pkg::F_PA:
                begin
                    pa_reg <= ps_rd;
                end
                gfr_pkg::F_PB:
                begin
                    pb_reg <= ps_rd;
                    dx_reg <= (pa_reg.x > ps_rd.x) ? pa_reg.x - ps_rd.x : ps_rd.x - pa_reg.x;
                    dy_reg <= (pa_reg.y > ps_rd.y) ? pa_reg.y - ps_rd.y : ps_rd.y - pa_reg.y;
                end
                gfr_pkg::F_SQY:
                begin
                    sq_reg <= (MW+1)'(mul_reg);
                end
                gfr_pkg::F_SQR:
                begin
                    sq_reg <= sq_reg + (MW+1)'(mul_reg);
                end
                gfr_pkg::F_CMP:
                begin
                    koff_reg <= koff_reg + PCW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    gfr_ram #(.WIDTH(gfr_pkg::PT_W), .DEPTH(MAX_POINTS)) u_point_ram (
        .clk(clk), .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
        .re(ps_re), .raddr(ps_raddr), .rdata(ps_rdata)
    );

    gfr_ram #(.WIDTH(PAW), .DEPTH(MAX_POINTS)) u_order_ram (
        .clk(clk), .we(bo_we), .waddr(bo_waddr), .wdata(bo_wdata),
        .re(bo_re), .raddr(bo_raddr), .rdata(bo_rdata)
    );

    gfr_ram #(.WIDTH(CAW), .DEPTH(MAX_POINTS)) u_cell_ram (
        .clk(clk), .we(cr_we), .waddr(cr_waddr), .wdata(cr_wdata),
        .re(cr_re), .raddr(cr_raddr), .rdata(cr_rdata)
    );

    gfr_ram #(.WIDTH(PCW), .DEPTH(MAX_CELLS + 1)) u_start_ram (
        .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
        .re(cs_re), .raddr(cs_raddr), .rdata(cs_rdata)
    );

    gfr_div #(.WIDTH(CW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(div_den), .quot(div_q), .done(div_done)
    );

    assign busy = (state_reg != gfr_pkg::S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `GFR_ASSERT_NXT(a_accept_goes_busy, start && !busy, busy, "accepted word did not raise busy")
    `GFR_ASSERT_IMP(a_done_after_work, done, $past(busy), "done without preceding work")
    `GFR_ASSERT_IMP(a_pair_types_differ, done && rsp.status == gfr_pkg::ST_PAIR,
                    rsp.first_type != rsp.second_type, "pair with equal feature types")
    `GFR_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= PCW'(MAX_POINTS), "point count overflow")

endmodule
